>>> hdl/hsv_to_rgb_converter_assert.svh
// assertion macros shared by the checker
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication, quiet while reset is low
`define HSVC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is low
`define HSVC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hsvc_pkg.sv
package hsvc_pkg;

    localparam int FULL_SCALE_DEF = 1000;

    localparam int HUE_W  = 12;
    localparam int SAT_W  = 10;
    localparam int VAL_W  = 10;
    localparam int DUTY_W = 10;
    localparam int FRAC_W = 10;
    localparam int PROD_W = SAT_W + FRAC_W;

    localparam int HUE_CIRCLE  = 3600;
    localparam int SECTOR_SPAN = 600;

    // pipeline layout
    localparam int TERMS_STAGES = 3;
    localparam int DIV_STAGES   = 3;
    localparam int PIPE_DEPTH   = TERMS_STAGES + DIV_STAGES + 1;

    typedef enum logic [2:0] {
        SECT_0,
        SECT_1,
        SECT_2,
        SECT_3,
        SECT_4,
        SECT_5
    } sector_t;

    typedef struct packed {
        sector_t             sector;
        logic [FRAC_W-1:0]   frac;
    } hue_split_t;

    function automatic int scale_w(input int fs);
        return $clog2(fs + 1);
    endfunction

    function automatic int den_w(input int fs);
        return $clog2(SECTOR_SPAN * fs + 1);
    endfunction

    function automatic int np_w(input int fs);
        return VAL_W + scale_w(fs);
    endfunction

    function automatic int nq_w(input int fs);
        return VAL_W + den_w(fs);
    endfunction

    // sector and fraction of a hue, out-of-circle hue wraps to zero
    function automatic hue_split_t hue_split(input logic [HUE_W-1:0] hue);
        hue_split_t       res;
        logic [HUE_W-1:0] h;
        h = (hue >= HUE_W'(HUE_CIRCLE)) ? '0 : hue;
        if (h >= HUE_W'(5 * SECTOR_SPAN))
        begin
            res.sector = SECT_5;
            res.frac   = FRAC_W'(h - HUE_W'(5 * SECTOR_SPAN));
        end
        else if (h >= HUE_W'(4 * SECTOR_SPAN))
        begin
            res.sector = SECT_4;
            res.frac   = FRAC_W'(h - HUE_W'(4 * SECTOR_SPAN));
        end
        else if (h >= HUE_W'(3 * SECTOR_SPAN))
        begin
            res.sector = SECT_3;
            res.frac   = FRAC_W'(h - HUE_W'(3 * SECTOR_SPAN));
        end
        else if (h >= HUE_W'(2 * SECTOR_SPAN))
        begin
            res.sector = SECT_2;
            res.frac   = FRAC_W'(h - HUE_W'(2 * SECTOR_SPAN));
        end
        else if (h >= HUE_W'(SECTOR_SPAN))
        begin
            res.sector = SECT_1;
            res.frac   = FRAC_W'(h - HUE_W'(SECTOR_SPAN));
        end
        else
        begin
            res.sector = SECT_0;
            res.frac   = FRAC_W'(h);
        end
        return res;
    endfunction

endpackage

>>> hdl/hsvc_in_if.sv
interface hsvc_in_if;
    import hsvc_pkg::*;

    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [VAL_W-1:0]  brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

>>> hdl/hsvc_out_if.sv
interface hsvc_out_if;
    import hsvc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  red_duty;
    logic [DUTY_W-1:0]  green_duty;
    logic [DUTY_W-1:0]  blue_duty;

    modport source (output valid, red_duty, green_duty, blue_duty, input ready);
    modport sink   (input valid, red_duty, green_duty, blue_duty, output ready);
endinterface

>>> hdl/hsv_to_rgb_converter.sv
// channel | role   | fields                                         | transaction
// --------+--------+------------------------------------------------+---------------
// hsv     | sink   | hue[11:0] saturation[9:0] brightness[9:0]      | valid && ready
// rgb     | source | red_duty[9:0] green_duty[9:0] blue_duty[9:0]   | valid && ready
//
// one transaction per clock sustained while the output is not stalled; seven register
// stages (three term stages, three divider stages and the channel-map output register),
// and a result passes the term stages, then the divider stages, into the output register
// each stage has its own valid bit and advances when empty or when the stage after
// it moves, so bubbles close up while the output is stalled
// reset clears only the valid bits; payload registers are not reset
module hsv_to_rgb_converter #(
    parameter int FULL_SCALE = hsvc_pkg::FULL_SCALE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hsvc_in_if.sink    hsv,
    hsvc_out_if.source rgb
);
    import hsvc_pkg::*;

    localparam int NP_W       = np_w(FULL_SCALE);
    localparam int NQ_W       = nq_w(FULL_SCALE);
    localparam int DIV_FIRST  = TERMS_STAGES + 1;
    localparam int DIV_LAST   = TERMS_STAGES + DIV_STAGES;
    localparam int OUT_STAGE  = PIPE_DEPTH;

    // stage control: en[k] loads stage k
    logic [PIPE_DEPTH:1]   vld_reg;
    logic [PIPE_DEPTH:1]   vld_next;
    logic [PIPE_DEPTH+1:1] en;

    always_comb
    begin
        en[PIPE_DEPTH+1] = rgb.ready;
        for (int k = PIPE_DEPTH; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next[1] = en[1] ? hsv.valid : vld_reg[1];
        for (int k = 2; k <= PIPE_DEPTH; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign hsv.ready = en[1];
    assign rgb.valid = vld_reg[OUT_STAGE];

    // term numerators: p over M, q and t over 600*M
    logic [NP_W-1:0]  np;
    logic [NQ_W-1:0]  nq;
    logic [NQ_W-1:0]  nt;
    logic [VAL_W-1:0] val_t;
    sector_t          sector_t3;

    hsvc_terms #(
        .FULL_SCALE (FULL_SCALE)
    ) u_terms (
        .clk        (clk),
        .en         (en[TERMS_STAGES:1]),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .np         (np),
        .nq         (nq),
        .nt         (nt),
        .val        (val_t),
        .sector     (sector_t3)
    );

    // constant dividers, one per term
    logic [DUTY_W-1:0] p_term;
    logic [DUTY_W-1:0] q_term;
    logic [DUTY_W-1:0] t_term;

    hsvc_cdiv #(
        .NUM_W   (NP_W),
        .DIVISOR (FULL_SCALE)
    ) u_div_p (
        .clk (clk),
        .en  (en[DIV_LAST:DIV_FIRST]),
        .num (np),
        .quo (p_term)
    );

    hsvc_cdiv #(
        .NUM_W   (NQ_W),
        .DIVISOR (SECTOR_SPAN * FULL_SCALE)
    ) u_div_q (
        .clk (clk),
        .en  (en[DIV_LAST:DIV_FIRST]),
        .num (nq),
        .quo (q_term)
    );

    hsvc_cdiv #(
        .NUM_W   (NQ_W),
        .DIVISOR (SECTOR_SPAN * FULL_SCALE)
    ) u_div_t (
        .clk (clk),
        .en  (en[DIV_LAST:DIV_FIRST]),
        .num (nt),
        .quo (t_term)
    );

    // sector and value ride alongside the dividers
    sector_t          sector_d_reg [DIV_STAGES];
    logic [VAL_W-1:0] val_d_reg    [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (en[DIV_FIRST])
        begin
            sector_d_reg[0] <= sector_t3;
            val_d_reg[0]    <= val_t;
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (en[DIV_FIRST + k])
            begin
                sector_d_reg[k] <= sector_d_reg[k-1];
                val_d_reg[k]    <= val_d_reg[k-1];
            end
        end
    end

    // channel map by sector, into the output register
    logic [DUTY_W-1:0] v_term;
    logic [DUTY_W-1:0] red_next;
    logic [DUTY_W-1:0] green_next;
    logic [DUTY_W-1:0] blue_next;
    logic [DUTY_W-1:0] red_reg;
    logic [DUTY_W-1:0] green_reg;
    logic [DUTY_W-1:0] blue_reg;

    assign v_term = DUTY_W'(val_d_reg[DIV_STAGES-1]);

    always_comb
    begin
        case (sector_d_reg[DIV_STAGES-1])
            SECT_0:
            begin
                red_next = v_term; green_next = t_term; blue_next = p_term;
            end
            SECT_1:
            begin
                red_next = q_term; green_next = v_term; blue_next = p_term;
            end
            SECT_2:
            begin
                red_next = p_term; green_next = v_term; blue_next = t_term;
            end
            SECT_3:
            begin
                red_next = p_term; green_next = q_term; blue_next = v_term;
            end
            SECT_4:
            begin
                red_next = t_term; green_next = p_term; blue_next = v_term;
            end
            SECT_5:
            begin
                red_next = v_term; green_next = p_term; blue_next = q_term;
            end
            default:
            begin
                red_next = v_term; green_next = p_term; blue_next = q_term;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.red_duty   = red_reg;
    assign rgb.green_duty = green_reg;
    assign rgb.blue_duty  = blue_reg;

endmodule

>>> hdl/hsvc_terms.sv
module hsvc_terms #(
    parameter int FULL_SCALE = hsvc_pkg::FULL_SCALE_DEF
) (
    input  logic                                   clk,
    input  logic [hsvc_pkg::TERMS_STAGES-1:0]      en,
    input  logic [hsvc_pkg::HUE_W-1:0]             hue,
    input  logic [hsvc_pkg::SAT_W-1:0]             saturation,
    input  logic [hsvc_pkg::VAL_W-1:0]             brightness,
    output logic [hsvc_pkg::np_w(FULL_SCALE)-1:0]  np,
    output logic [hsvc_pkg::nq_w(FULL_SCALE)-1:0]  nq,
    output logic [hsvc_pkg::nq_w(FULL_SCALE)-1:0]  nt,
    output logic [hsvc_pkg::VAL_W-1:0]             val,
    output hsvc_pkg::sector_t                      sector
);
    import hsvc_pkg::*;

    localparam int SC_W = scale_w(FULL_SCALE);
    localparam int DN_W = den_w(FULL_SCALE);
    localparam int NP_W = np_w(FULL_SCALE);
    localparam int NQ_W = nq_w(FULL_SCALE);

    localparam logic [SAT_W-1:0] SAT_CAP =
        (FULL_SCALE >= (1 << SAT_W)) ? '1 : SAT_W'(FULL_SCALE);
    localparam logic [VAL_W-1:0] VAL_CAP =
        (FULL_SCALE >= (1 << VAL_W)) ? '1 : VAL_W'(FULL_SCALE);
    localparam logic [SC_W-1:0] SCALE_V = SC_W'(FULL_SCALE);
    localparam logic [DN_W-1:0] DEN_V   = DN_W'(SECTOR_SPAN * FULL_SCALE);

    // stage 1: hue split, clamp to full scale
    hue_split_t        split_next;
    logic [SAT_W-1:0]  sat_next;
    logic [VAL_W-1:0]  val_next;

    sector_t           sector_s1_reg;
    logic [FRAC_W-1:0] frac_s1_reg;
    logic [SAT_W-1:0]  sat_s1_reg;
    logic [VAL_W-1:0]  val_s1_reg;

    always_comb
    begin
        split_next = hue_split(hue);
        sat_next   = (saturation > SAT_CAP) ? SAT_CAP : saturation;
        val_next   = (brightness > VAL_CAP) ? VAL_CAP : brightness;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sector_s1_reg <= split_next.sector;
            frac_s1_reg   <= split_next.frac;
            sat_s1_reg    <= sat_next;
            val_s1_reg    <= val_next;
        end
    end

    // stage 2: p numerator, s*f and s*(600-f)
    logic [SC_W-1:0]   diff_next;
    logic [NP_W-1:0]   np_next;
    logic [PROD_W-1:0] sf_next;
    logic [PROD_W-1:0] sg_next;

    sector_t           sector_s2_reg;
    logic [VAL_W-1:0]  val_s2_reg;
    logic [NP_W-1:0]   np_s2_reg;
    logic [PROD_W-1:0] sf_s2_reg;
    logic [PROD_W-1:0] sg_s2_reg;

    always_comb
    begin
        diff_next = SCALE_V - SC_W'(sat_s1_reg);
        np_next   = NP_W'(val_s1_reg) * NP_W'(diff_next);
        sf_next   = PROD_W'(sat_s1_reg) * PROD_W'(frac_s1_reg);
        sg_next   = PROD_W'(sat_s1_reg)
                  * PROD_W'(FRAC_W'(SECTOR_SPAN) - frac_s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sector_s2_reg <= sector_s1_reg;
            val_s2_reg    <= val_s1_reg;
            np_s2_reg     <= np_next;
            sf_s2_reg     <= sf_next;
            sg_s2_reg     <= sg_next;
        end
    end

    // stage 3: q and t numerators
    logic [DN_W-1:0]   qd_next;
    logic [DN_W-1:0]   td_next;
    logic [NQ_W-1:0]   nq_next;
    logic [NQ_W-1:0]   nt_next;

    sector_t           sector_s3_reg;
    logic [VAL_W-1:0]  val_s3_reg;
    logic [NP_W-1:0]   np_s3_reg;
    logic [NQ_W-1:0]   nq_s3_reg;
    logic [NQ_W-1:0]   nt_s3_reg;

    always_comb
    begin
        qd_next = DEN_V - DN_W'(sf_s2_reg);
        td_next = DEN_V - DN_W'(sg_s2_reg);
        nq_next = NQ_W'(val_s2_reg) * NQ_W'(qd_next);
        nt_next = NQ_W'(val_s2_reg) * NQ_W'(td_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sector_s3_reg <= sector_s2_reg;
            val_s3_reg    <= val_s2_reg;
            np_s3_reg     <= np_s2_reg;
            nq_s3_reg     <= nq_next;
            nt_s3_reg     <= nt_next;
        end
    end

    assign np     = np_s3_reg;
    assign nq     = nq_s3_reg;
    assign nt     = nt_s3_reg;
    assign val    = val_s3_reg;
    assign sector = sector_s3_reg;

endmodule

>>> hdl/hsvc_cdiv.sv
module hsvc_cdiv #(
    parameter int NUM_W   = 22,
    parameter int DIVISOR = hsvc_pkg::FULL_SCALE_DEF
) (
    input  logic                               clk,
    input  logic [hsvc_pkg::DIV_STAGES-1:0]    en,
    input  logic [NUM_W-1:0]                   num,
    output logic [hsvc_pkg::DUTY_W-1:0]        quo
);
    import hsvc_pkg::*;

    // floor(2^NUM_W / DIVISOR) underestimates the quotient by at most one
    localparam logic [63:0] RECIP = (64'd1 << NUM_W) / 64'(DIVISOR);
    localparam int R_W   = $clog2(RECIP + 1);
    localparam int PRD_W = NUM_W + R_W;
    localparam int REM_W = $clog2(2 * DIVISOR);
    localparam logic [R_W-1:0]   RECIP_V = R_W'(RECIP);
    localparam logic [NUM_W-1:0] DIV_V   = NUM_W'(DIVISOR);
    localparam logic [REM_W-1:0] DIV_R   = REM_W'(DIVISOR);

    // stage a: estimate by reciprocal
    logic [PRD_W-1:0]  prd_next;
    logic [DUTY_W-1:0] est_a_reg;
    logic [NUM_W-1:0]  num_a_reg;

    assign prd_next = PRD_W'(num) * PRD_W'(RECIP_V);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            est_a_reg <= prd_next[NUM_W +: DUTY_W];
            num_a_reg <= num;
        end
    end

    // stage b: remainder, below twice the divisor
    logic [NUM_W-1:0]  back_next;
    logic [NUM_W-1:0]  rem_next;
    logic [DUTY_W-1:0] est_b_reg;
    logic [REM_W-1:0]  rem_b_reg;

    always_comb
    begin
        back_next = NUM_W'(est_a_reg) * DIV_V;
        rem_next  = num_a_reg - back_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            est_b_reg <= est_a_reg;
            rem_b_reg <= rem_next[REM_W-1:0];
        end
    end

    // stage c: correct by one
    logic [DUTY_W-1:0] quo_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            quo_c_reg <= est_b_reg + DUTY_W'(rem_b_reg >= DIV_R);
        end
    end

    assign quo = quo_c_reg;

endmodule

>>> hdl/hsvc_checker.sv
`include "hsv_to_rgb_converter_assert.svh"

module hsvc_checker #(
    parameter int FULL_SCALE = hsvc_pkg::FULL_SCALE_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        hsv_valid,
    input logic                        hsv_ready,
    input logic                        rgb_valid,
    input logic                        rgb_ready,
    input logic [hsvc_pkg::DUTY_W-1:0] red_duty,
    input logic [hsvc_pkg::DUTY_W-1:0] green_duty,
    input logic [hsvc_pkg::DUTY_W-1:0] blue_duty
);
    import hsvc_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    // transactions taken in but not yet delivered
    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg
                     + CNT_W'(hsv_valid && hsv_ready)
                     - CNT_W'(rgb_valid && rgb_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `HSVC_ASSERT_IMPL(a_no_phantom, clk, rst_n, rgb_valid, pending_reg != '0, "output with nothing in flight")
    `HSVC_ASSERT_IMPL(a_depth, clk, rst_n, 1'b1, pending_reg <= CNT_W'(PIPE_DEPTH), "more in flight than stages")
    `HSVC_ASSERT_IMPL(a_full_stall, clk, rst_n, (pending_reg == CNT_W'(PIPE_DEPTH)) && !rgb_ready, !hsv_ready, "full and stalled yet ready")
    `HSVC_ASSERT_IMPL(a_range, clk, rst_n, rgb_valid, (red_duty <= FULL_SCALE) && (green_duty <= FULL_SCALE) && (blue_duty <= FULL_SCALE), "duty above full scale")
    `HSVC_ASSERT_NEXT(a_hold, clk, rst_n, rgb_valid && !rgb_ready, rgb_valid && $stable(red_duty) && $stable(green_duty) && $stable(blue_duty), "stalled output changed")

endmodule

bind hsv_to_rgb_converter hsvc_checker #(
    .FULL_SCALE (FULL_SCALE)
) u_hsvc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .hsv_valid  (hsv.valid),
    .hsv_ready  (hsv.ready),
    .rgb_valid  (rgb.valid),
    .rgb_ready  (rgb.ready),
    .red_duty   (rgb.red_duty),
    .green_duty (rgb.green_duty),
    .blue_duty  (rgb.blue_duty)
);

>>> tb/sv/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
    import hsvc_pkg::*;

    localparam int FULL_SCALE  = FULL_SCALE_DEF;
    // cycles with no transaction on either side before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    // random idling on both sides, in percent
    localparam int IDLE_PCT    = 18;
    localparam int RANDOM_HSV  = 800;

    // one expected output color
    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } rgb_duty_t;

    // keeps the colors still owed by the pipeline and checks each output against them
    class hsv_rgb_scoreboard;
        rgb_duty_t   rgb_due[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // exact integer hsv to rgb conversion with truncation
        function rgb_duty_t rgb_of_hsv(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                       logic [VAL_W-1:0] bri);
            longint unsigned m, s, v, h, f, den, p, q, t, r, g, b;
            sector_t         sect;
            rgb_duty_t       res;
            m = FULL_SCALE;
            // over-range saturation and value clip to full scale
            s = (sat > m) ? m : sat;
            v = (bri > m) ? m : bri;
            // hue past the full circle counts as zero
            h = (hue >= HUE_CIRCLE) ? 0 : hue;
            sect = sector_t'(h / SECTOR_SPAN);
            f = h % SECTOR_SPAN;
            den = SECTOR_SPAN * m;
            p = (v * (m - s)) / m;
            q = (v * (den - s * f)) / den;
            t = (v * (den - s * (SECTOR_SPAN - f))) / den;
            case (sect)
                SECT_0: begin r = v; g = t; b = p; end
                SECT_1: begin r = q; g = v; b = p; end
                SECT_2: begin r = p; g = v; b = t; end
                SECT_3: begin r = p; g = q; b = v; end
                SECT_4: begin r = t; g = p; b = v; end
                default: begin r = v; g = p; b = q; end
            endcase
            res.red   = DUTY_W'(r);
            res.green = DUTY_W'(g);
            res.blue  = DUTY_W'(b);
            return res;
        endfunction

        function void note_hsv(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                               logic [VAL_W-1:0] bri);
            rgb_due.push_back(rgb_of_hsv(hue, sat, bri));
        endfunction

        function void check_rgb(logic [DUTY_W-1:0] red, logic [DUTY_W-1:0] green,
                                logic [DUTY_W-1:0] blue);
            rgb_duty_t want;
            if (rgb_due.size() == 0)
            begin
                $error("rgb transaction with no color expected: %0d %0d %0d",
                       red, green, blue);
                mismatches++;
                return;
            end
            want = rgb_due.pop_front();
            if (red !== want.red)
            begin
                $error("red_duty: expected %0d, actual %0d", want.red, red);
                mismatches++;
            end
            if (green !== want.green)
            begin
                $error("green_duty: expected %0d, actual %0d", want.green, green);
                mismatches++;
            end
            if (blue !== want.blue)
            begin
                $error("blue_duty: expected %0d, actual %0d", want.blue, blue);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    // when set, neither side idles
    bit steady_flow;

    int unsigned quiet_cycles = 0;

    hsv_rgb_scoreboard scoreboard;

    hsvc_in_if  hsv_bus();
    hsvc_out_if rgb_bus();

    hsv_to_rgb_converter #(
        .FULL_SCALE(FULL_SCALE)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_bus),
        .rgb   (rgb_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // output side: back-pressure at random, changed on the falling edge only
    initial
    begin
        rgb_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                rgb_bus.ready <= 1'b0;
            else
                rgb_bus.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // both channels are sampled on the rising edge; inputs were settled at the falling one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hsv_bus.valid && hsv_bus.ready)
                scoreboard.note_hsv(hsv_bus.hue, hsv_bus.saturation, hsv_bus.brightness);
            if (rgb_bus.valid && rgb_bus.ready)
                scoreboard.check_rgb(rgb_bus.red_duty, rgb_bus.green_duty, rgb_bus.blue_duty);
        end
    end

    // hang detector: any transaction on either side clears the count
    always @(posedge clk)
    begin
        if ((hsv_bus.valid && hsv_bus.ready) || (rgb_bus.valid && rgb_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one color and hold it until the converter takes it
    task automatic push_hsv(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                            input logic [VAL_W-1:0] bri);
        @(negedge clk);
        // random gap before the transaction
        while (!steady_flow && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            hsv_bus.valid <= 1'b0;
            @(negedge clk);
        end
        hsv_bus.valid      <= 1'b1;
        hsv_bus.hue        <= hue;
        hsv_bus.saturation <= sat;
        hsv_bus.brightness <= bri;
        @(posedge clk);
        while (!hsv_bus.ready)
            @(posedge clk);
    endtask

    // mostly colors inside the legal ranges, some with over-range fields
    task automatic push_random_hsv();
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] bri;
        if ($urandom_range(0, 9) < 7)
            hue = HUE_W'($urandom_range(0, HUE_CIRCLE - 1));
        else
            hue = HUE_W'($urandom);
        if ($urandom_range(0, 9) < 8)
            sat = SAT_W'($urandom_range(0, FULL_SCALE));
        else
            sat = SAT_W'($urandom);
        if ($urandom_range(0, 9) < 8)
            bri = VAL_W'($urandom_range(0, FULL_SCALE));
        else
            bri = VAL_W'($urandom);
        push_hsv(hue, sat, bri);
    endtask

    initial
    begin
        // every input known from time zero
        rst_n              = 1'b0;
        hsv_bus.valid      = 1'b0;
        hsv_bus.hue        = '0;
        hsv_bus.saturation = '0;
        hsv_bus.brightness = '0;
        steady_flow        = 1'b0;
        scoreboard         = new();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // sector edges at full saturation and value
        push_hsv(0, 1000, 1000);
        push_hsv(599, 1000, 1000);
        push_hsv(600, 1000, 1000);
        push_hsv(1200, 1000, 1000);
        push_hsv(1799, 1023, 1023);
        push_hsv(1800, 1000, 1000);
        push_hsv(2400, 1000, 1000);
        push_hsv(3000, 1000, 1000);
        push_hsv(3599, 1000, 1000);
        // hue past the circle wraps to zero
        push_hsv(3600, 1000, 1000);
        push_hsv(4095, 1023, 1023);
        push_hsv(4095, 0, 0);
        // zero saturation gives grey
        push_hsv(1500, 0, 700);
        push_hsv(2000, 0, 1023);
        // over-range saturation and value, then assorted other colors
        push_hsv(900, 1023, 0);
        push_hsv(2345, 1001, 1001);
        push_hsv(300, 500, 1000);
        push_hsv(0, 0, 0);
        push_hsv(2999, 1, 1);
        push_hsv(3001, 999, 999);
        push_hsv(1, 1000, 1);
        push_hsv(4000, 512, 511);

        for (int i = 0; i < RANDOM_HSV; i++)
        begin
            // a stretch at full rate on both sides
            steady_flow = (i >= 300) && (i < 450);
            push_random_hsv();
        end
        steady_flow = 1'b0;

        @(negedge clk);
        hsv_bus.valid <= 1'b0;

        // drain, then give the pipeline time to show any extra transaction
        while (scoreboard.rgb_due.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (scoreboard.rgb_due.size() != 0)
        begin
            $error("%0d rgb transactions never arrived", scoreboard.rgb_due.size());
            scoreboard.mismatches++;
        end

        if (scoreboard.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/hsvc_pkg.sv
hdl/hsvc_in_if.sv
hdl/hsvc_out_if.sv
hdl/hsvc_terms.sv
hdl/hsvc_cdiv.sv
hdl/hsv_to_rgb_converter.sv
hdl/hsvc_checker.sv
tb/sv/tb_hsv_to_rgb_converter.sv
